// ===== sv/mfnd_pkg.sv =====
// Shared types, operation codes and constants for the mixed fraction normalize/divide block.
package mfnd_pkg;

	typedef struct packed {
		logic        cmd;
		logic [31:0] whole_in;
		logic [31:0] int_part;
		logic [31:0] num;
		logic [31:0] den;
	} req_t;

	typedef struct packed {
		logic [31:0] out_whole;
		logic [31:0] out_num;
		logic [31:0] out_den;
		logic [1:0]  status;
	} rsp_t;

	// Datapath operations issued by the controller
	localparam logic [4:0] OP_NONE       = 5'd0;
	localparam logic [4:0] OP_LOAD       = 5'd1;
	localparam logic [4:0] OP_FOLD_START = 5'd2;
	localparam logic [4:0] OP_DIV_STEP   = 5'd3;
	localparam logic [4:0] OP_FOLD_END   = 5'd4;
	localparam logic [4:0] OP_GCD_START  = 5'd5;
	localparam logic [4:0] OP_GCD_STEP   = 5'd6;
	localparam logic [4:0] OP_RB_START   = 5'd7;
	localparam logic [4:0] OP_RB_END     = 5'd8;
	localparam logic [4:0] OP_RC_START   = 5'd9;
	localparam logic [4:0] OP_RC_END     = 5'd10;
	localparam logic [4:0] OP_SAT        = 5'd11;
	localparam logic [4:0] OP_ADD        = 5'd12;
	localparam logic [4:0] OP_MUL1       = 5'd13;
	localparam logic [4:0] OP_MUL2       = 5'd14;
	localparam logic [4:0] OP_MUL3       = 5'd15;
	localparam logic [4:0] OP_SHIFT      = 5'd16;
	localparam logic [4:0] OP_DLOAD      = 5'd17;
	localparam logic [4:0] OP_ERR        = 5'd18;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic [31:0] RED_MIN   = 32'd3;
	localparam logic [6:0]  STEPS_32  = 7'd32;
	localparam logic [6:0]  STEPS_64  = 7'd64;

	typedef struct packed {
		logic [4:0] op;
		logic       emit;
	} ctl_t;

	typedef struct packed {
		logic den_zero;
		logic b_ge_c;
		logic reduce_ok;
		logic gcd_done;
		logic div_done;
		logic dvs_zero;
		logic dvs_wide;
		logic cmd;
	} sts_t;

endpackage

// ===== sv/mfnd_dp.sv =====
// Datapath: fraction registers, shared restoring divider, binary gcd and multiplier.
module mfnd_dp
	import mfnd_pkg::*;
#(
	parameter int DEN_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	input  req_t       req,
	output sts_t       sts,
	output rsp_t       res
);

	logic [32:0] a_q;
	logic [31:0] b_q, c_q, n_q;
	logic        cmd_q, err_q, sat_q;
	logic [63:0] dvd_q, dvs_q, rem_q, mul_q;
	logic [6:0]  cnt_q;
	logic [31:0] u_q, v_q;
	logic [4:0]  k_q;

	logic [64:0] rem_sh, rem_nx, dvs_ext;
	logic        q_bit;
	logic [31:0] gcd_g;
	logic [32:0] quo_clamp;
	logic [31:0] mul_a;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[63]};
		dvs_ext = {1'b0, dvs_q};
		q_bit   = rem_sh >= dvs_ext;
		rem_nx  = q_bit ? (rem_sh - dvs_ext) : rem_sh;
		gcd_g   = u_q << k_q;
		quo_clamp = (dvd_q > 64'h1_0000_0000) ? 33'h1_0000_0000 : dvd_q[32:0];
		mul_a   = (ctl.op == OP_MUL1) ? n_q : a_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					err_q <= 1'b0;
					sat_q <= 1'b0;
				end
				OP_FOLD_START, OP_RB_START, OP_RC_START: cnt_q <= STEPS_32;
				OP_MUL3: cnt_q <= STEPS_64;
				OP_DIV_STEP: cnt_q <= cnt_q - 7'd1;
				OP_SAT: if (a_q[32]) sat_q <= 1'b1;
				OP_ERR: err_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				a_q   <= {1'b0, req.int_part};
				b_q   <= req.num;
				c_q   <= req.den;
				n_q   <= req.whole_in;
				cmd_q <= req.cmd;
			end
			OP_FOLD_START: begin
				dvd_q <= {b_q, 32'd0};
				dvs_q <= {32'd0, c_q};
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_nx[63:0];
				dvd_q <= {dvd_q[62:0], q_bit};
			end
			OP_FOLD_END: begin
				a_q <= a_q + {1'b0, dvd_q[31:0]};
				b_q <= rem_q[31:0];
			end
			OP_GCD_START: begin
				u_q <= b_q;
				v_q <= c_q;
				k_q <= '0;
			end
			OP_GCD_STEP: begin
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 5'd1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= v_q;
					v_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			OP_RB_START: begin
				dvd_q <= {b_q, 32'd0};
				dvs_q <= {32'd0, gcd_g};
				rem_q <= '0;
			end
			OP_RB_END: b_q <= dvd_q[31:0];
			OP_RC_START: begin
				dvd_q <= {c_q, 32'd0};
				dvs_q <= {32'd0, gcd_g};
				rem_q <= '0;
			end
			OP_RC_END: c_q <= dvd_q[31:0];
			OP_SAT: if (a_q[32]) a_q <= {1'b0, 32'hFFFF_FFFF};
			OP_ADD: a_q <= {1'b0, a_q[31:0]} + {1'b0, n_q};
			OP_MUL1: mul_q <= mul_a * c_q;
			OP_MUL2: begin
				dvd_q <= mul_q;
				mul_q <= mul_a * c_q;
			end
			OP_MUL3: begin
				dvs_q <= mul_q + {32'd0, b_q};
				rem_q <= '0;
			end
			OP_SHIFT: begin
				dvs_q <= dvs_q >> 1;
				rem_q <= rem_q >> 1;
			end
			OP_DLOAD: begin
				// remainder can only reach the divisor after the shift, so fold at most one
				if (rem_q >= dvs_q) begin
					a_q <= quo_clamp + 33'd1;
					b_q <= rem_q[31:0] - dvs_q[31:0];
				end else begin
					a_q <= quo_clamp;
					b_q <= rem_q[31:0];
				end
				c_q <= dvs_q[31:0];
			end
			OP_ERR: begin
				a_q <= '0;
				b_q <= '0;
				c_q <= 32'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.den_zero  = c_q == 32'd0;
		sts.b_ge_c    = b_q >= c_q;
		sts.reduce_ok = (b_q > RED_MIN) && (c_q > RED_MIN);
		sts.gcd_done  = v_q == 32'd0;
		sts.div_done  = cnt_q == 7'd0;
		sts.dvs_zero  = dvs_q == 64'd0;
		sts.dvs_wide  = (dvs_q >> DEN_BITS) != 64'd0;
		sts.cmd       = cmd_q;
		res.out_whole = a_q[31:0];
		res.out_num   = b_q;
		res.out_den   = c_q;
		res.status    = err_q ? STAT_ZERO : (sat_q ? STAT_SAT : STAT_OK);
	end

	// whole part fits 32 bits once saturation has been applied
	a_sat_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_SAT |=> !a_q[32])
		else $error("whole part still wide after saturation");

	// divider count runs down one per step
	div_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_DIV_STEP |=> cnt_q == $past(cnt_q) - 7'd1)
		else $error("divider count slipped");

	// a handed-off fraction is proper
	rsp_proper: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> b_q < c_q)
		else $error("numerator not below denominator at hand-off");

endmodule

// ===== sv/mfnd_ctrl.sv =====
// Controller: sequences load, fold, gcd reduction, add or divide, and result hand-off.
module mfnd_ctrl
	import mfnd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic rsp_free,
	input  sts_t sts,
	output ctl_t ctl,
	output logic req_stall
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHK    = 5'd1;
	localparam logic [4:0] S_FOLD   = 5'd2;
	localparam logic [4:0] S_FDIV   = 5'd3;
	localparam logic [4:0] S_GCHK   = 5'd4;
	localparam logic [4:0] S_GCD    = 5'd5;
	localparam logic [4:0] S_RBDIV  = 5'd6;
	localparam logic [4:0] S_RC     = 5'd7;
	localparam logic [4:0] S_RCDIV  = 5'd8;
	localparam logic [4:0] S_SAT    = 5'd9;
	localparam logic [4:0] S_BRANCH = 5'd10;
	localparam logic [4:0] S_ADD    = 5'd11;
	localparam logic [4:0] S_MUL1   = 5'd12;
	localparam logic [4:0] S_MUL2   = 5'd13;
	localparam logic [4:0] S_MUL3   = 5'd14;
	localparam logic [4:0] S_ZCHK   = 5'd15;
	localparam logic [4:0] S_DIV    = 5'd16;
	localparam logic [4:0] S_SHIFT  = 5'd17;
	localparam logic [4:0] S_ERR    = 5'd18;
	localparam logic [4:0] S_EMIT   = 5'd19;

	logic [4:0] state_q, state_d;
	logic       pass_q, pass_d;

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		ctl.op   = OP_NONE;
		ctl.emit = 1'b0;
		case (state_q)
			S_IDLE: begin
				pass_d = 1'b0;
				if (req_valid) begin
					ctl.op  = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: state_d = sts.den_zero ? S_ERR : S_FOLD;
			S_FOLD: begin
				if (sts.b_ge_c) begin
					ctl.op  = OP_FOLD_START;
					state_d = S_FDIV;
				end else begin
					state_d = S_GCHK;
				end
			end
			S_FDIV: begin
				if (sts.div_done) begin
					ctl.op  = OP_FOLD_END;
					state_d = S_GCHK;
				end else begin
					ctl.op = OP_DIV_STEP;
				end
			end
			S_GCHK: begin
				if (sts.reduce_ok) begin
					ctl.op  = OP_GCD_START;
					state_d = S_GCD;
				end else begin
					state_d = S_SAT;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					ctl.op  = OP_RB_START;
					state_d = S_RBDIV;
				end else begin
					ctl.op = OP_GCD_STEP;
				end
			end
			S_RBDIV: begin
				if (sts.div_done) begin
					ctl.op  = OP_RB_END;
					state_d = S_RC;
				end else begin
					ctl.op = OP_DIV_STEP;
				end
			end
			S_RC: begin
				ctl.op  = OP_RC_START;
				state_d = S_RCDIV;
			end
			S_RCDIV: begin
				if (sts.div_done) begin
					ctl.op  = OP_RC_END;
					state_d = S_SAT;
				end else begin
					ctl.op = OP_DIV_STEP;
				end
			end
			S_SAT: begin
				ctl.op  = OP_SAT;
				state_d = S_BRANCH;
			end
			S_BRANCH: begin
				if (pass_q)
					state_d = S_EMIT;
				else
					state_d = sts.cmd ? S_MUL1 : S_ADD;
			end
			S_ADD: begin
				ctl.op  = OP_ADD;
				pass_d  = 1'b1;
				state_d = S_SAT;
			end
			S_MUL1: begin
				ctl.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				ctl.op  = OP_MUL2;
				state_d = S_MUL3;
			end
			S_MUL3: begin
				ctl.op  = OP_MUL3;
				state_d = S_ZCHK;
			end
			S_ZCHK: state_d = sts.dvs_zero ? S_ERR : S_DIV;
			S_DIV: begin
				if (sts.div_done)
					state_d = S_SHIFT;
				else
					ctl.op = OP_DIV_STEP;
			end
			S_SHIFT: begin
				// drop one bit from remainder and divisor until the divisor fits
				if (sts.dvs_wide) begin
					ctl.op = OP_SHIFT;
				end else begin
					ctl.op  = OP_DLOAD;
					pass_d  = 1'b1;
					state_d = S_GCHK;
				end
			end
			S_ERR: begin
				ctl.op  = OP_ERR;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (rsp_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

	// an accepted request always goes to the zero-denominator check first
	accept_to_chk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && req_valid |=> state_q == S_CHK)
		else $error("request not followed by denominator check");

	// a result is handed over only after an error or the final pass
	emit_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> state_q == S_EMIT && rsp_free)
		else $error("result handed over out of turn");

	// divide steps never run past the end of the count
	step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_DIV_STEP |-> !sts.div_done)
		else $error("divider stepped after completion");

endmodule

// ===== sv/mixed_fraction_normalize_divide.sv =====
// Top level of the mixed fraction normalize/divide block with its result register.
//
// Request channel (req_valid, req_stall, req): one mixed fraction int_part + num/den,
// a whole number and a command. Command 0 adds the whole number; command 1 divides
// it by the fraction and scales remainder and divisor down to DEN_BITS bits.
// Response channel (rsp_valid, rsp_stall, rsp): normalized whole, numerator,
// denominator and status (0 ok, 1 zero denominator or divisor, 2 saturated).
// One request is worked at a time. The zero-denominator case finishes soonest and
// the divide path takes longest; the time is set by the one-bit-per-cycle
// restoring divider (32 or 64 steps per division, up to six divisions), the
// subtract-and-shift gcd loop and the one-bit-per-cycle divisor scaling.
// The finished result sits in an output register; a new request is taken while it
// waits, and a stalled response holds its payload until taken. Work completes but
// waits in place when the register is still full.
// Reset clears the controller and the output valid; no clearing pass is needed.
module mixed_fraction_normalize_divide
	import mfnd_pkg::*;
#(
	parameter int DEN_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	mfnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_free  (rsp_free),
		.sts       (sts),
		.ctl       (ctl),
		.req_stall (req_stall)
	);

	mfnd_dp #(
		.DEN_BITS (DEN_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
